### rtl/bbcc_pkg.sv
package bbcc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxBlocksDefault   = 65536;
  localparam int unsigned MaxErrorsDefault   = 64;
  localparam int unsigned DirectSlotsDefault = 12;

  // Reset value of the total-blocks configuration register
  localparam logic [16:0] TotalBlocksReset = 17'd65536;

  // Bit of the inode mode word that marks a directory
  localparam int unsigned DirBit = 1;

  // Width of one bitmap row
  localparam int unsigned RowBits = 32;

  // Index of the last counter report
  localparam logic [3:0] CntIdLast = 4'd9;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TOTAL_BLOCKS     = 3'd0,
    CFG_FIRST_DATA_BLOCK = 3'd1,
    CFG_TOTAL_INODES     = 3'd2,
    CFG_EXPECTED_MAGIC   = 3'd3,
    CFG_EXPECTED_VERSION = 3'd4
  } cfg_idx_e;

  // Item modes
  typedef enum logic [2:0] {
    MODE_SUPER  = 3'd0,
    MODE_INODE  = 3'd1,
    MODE_REF    = 3'd2,
    MODE_ORPHAN = 3'd3,
    MODE_FINISH = 3'd4
  } mode_e;

  // Error record codes
  typedef enum logic [2:0] {
    ERR_MAGIC        = 3'd0,
    ERR_VERSION      = 3'd1,
    ERR_ORPHAN_INODE = 3'd2,
    ERR_DOUBLE_INODE = 3'd3,
    ERR_BAD_LINK     = 3'd4,
    ERR_CROSSLINK    = 3'd5,
    ERR_ORPHAN_BLOCK = 3'd6,
    ERR_ROOT         = 3'd7
  } err_code_e;

  // Result kinds
  typedef enum logic {
    KIND_ERROR   = 1'b0,
    KIND_COUNTER = 1'b1
  } kind_e;

  // Statistic counter slots
  localparam logic [2:0] ScInodesUsed   = 3'd0;
  localparam logic [2:0] ScBlocksUsed   = 3'd1;
  localparam logic [2:0] ScDirs         = 3'd2;
  localparam logic [2:0] ScFiles        = 3'd3;
  localparam logic [2:0] ScOrphanInodes = 3'd4;
  localparam logic [2:0] ScOrphanBlocks = 3'd5;
  localparam logic [2:0] ScCrosslinks   = 3'd6;
  localparam int unsigned NumStat       = 7;

  // Shared arithmetic unit
  typedef enum logic {
    ALU_INC = 1'b0,  // saturating increment of a
    ALU_SUB = 1'b1   // a - b, floored at zero
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

endpackage

### rtl/block_bitmap_consistency_checker.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------------
// request   mode_i .. bmap_bit_i                    taken when start & !busy
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i        written when cfg_we_i
// result    kind_o .. last_o                        one cycle each, marked res_valid_o
//
// Superblock, inode header and ignored requests use ST_EXEC only (plus up to 3
// counter bumps for an inode header); a reference or scan block that reaches the
// bitmap has its row read in ST_EXEC and tested in ST_RMW, which writes a reference
// row back unless cross-linked. After a bad magic every request is taken and dropped.
// After reset the bitmap memory is cleared one row per cycle (MAX_BLOCKS/32 rows,
// rounded up); busy stays high meanwhile. Results cannot be stalled.
module block_bitmap_consistency_checker #(
  parameter int unsigned MAX_BLOCKS   = bbcc_pkg::MaxBlocksDefault,
  parameter int unsigned MAX_ERRORS   = bbcc_pkg::MaxErrorsDefault,
  parameter int unsigned DIRECT_SLOTS = bbcc_pkg::DirectSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [31:0] magic_value_i,
  input  logic [31:0] version_value_i,
  input  logic [15:0] inode_number_i,
  input  logic [15:0] inode_kind_bits_i,
  input  logic [31:0] file_size_i,
  input  logic [15:0] link_count_i,
  input  logic        imap_bit_i,
  input  logic [31:0] block_number_i,
  input  logic [3:0]  slot_i,
  input  logic        bmap_bit_i,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // result
  output logic        res_valid_o,
  output logic        kind_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] inode_num_o,
  output logic [31:0] block_num_o,
  output logic [31:0] detail_o,
  output logic [3:0]  counter_id_o,
  output logic [31:0] counter_value_o,
  output logic        clean_o,
  output logic        last_o
);

  localparam int unsigned Rows  = (MAX_BLOCKS + bbcc_pkg::RowBits - 1) / bbcc_pkg::RowBits;
  localparam int unsigned AddrW = $clog2(Rows);
  localparam logic [AddrW-1:0] LastRow = AddrW'(Rows - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_RMW   = 6'b001000,
    ST_BUMP  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [3:0]  k_q, k_d;
  logic [6:0]  pend_q, pend_d;
  logic [31:0] stat_q [bbcc_pkg::NumStat];
  logic [31:0] stat_d [bbcc_pkg::NumStat];
  logic [31:0] err_total_q, err_total_d;
  logic        clean_q, clean_d;
  logic        aborted_q, aborted_d;
  logic [15:0] cur_ino_q, cur_ino_d;
  logic        cur_used_q, cur_used_d;
  logic [15:0] root_mode_q, root_mode_d;

  // Configuration registers
  logic [16:0] total_blocks_q, first_data_block_q, total_inodes_q;
  logic [31:0] exp_magic_q, exp_version_q;

  // Latched request
  logic [2:0]  it_mode_q;
  logic [31:0] it_magic_q, it_version_q, it_size_q, it_blk_q;
  logic [15:0] it_ino_q, it_kb_q, it_lc_q;
  logic        it_imap_q, it_bm_q;
  logic [3:0]  it_slot_q;

  // Result registers
  logic        out_valid_q, out_valid_d;
  logic        out_kind_q, out_kind_d;
  logic [2:0]  out_code_q, out_code_d;
  logic [15:0] out_ino_q, out_ino_d;
  logic [31:0] out_blk_q, out_blk_d;
  logic [31:0] out_det_q, out_det_d;
  logic [3:0]  out_cid_q, out_cid_d;
  logic [31:0] out_cval_q, out_cval_d;
  logic        out_clean_q, out_clean_d;
  logic        out_last_q, out_last_d;

  // Shared unit and memory
  bbcc_pkg::alu_req_t alu_req;
  logic [31:0] alu_y;
  logic        ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [bbcc_pkg::RowBits-1:0] ram_wdata, ram_rdata;

  // Error raised in this cycle
  logic        err_fire, err_last;
  logic [2:0]  err_code;
  logic [15:0] err_ino;
  logic [31:0] err_blk, err_det;

  logic [31:0] bound;
  logic        blk_in_range, direct_slot, item_used, seen_bit;
  logic [2:0]  bump_idx;

  bbcc_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  bbcc_bitmap_ram #(
    .Rows  (Rows),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Range checks on the latched request
  assign bound = (32'(total_blocks_q) < 32'(MAX_BLOCKS)) ? 32'(total_blocks_q)
                                                         : 32'(MAX_BLOCKS);
  assign blk_in_range = it_blk_q < bound;
  assign direct_slot  = {1'b0, it_slot_q} < 5'(DIRECT_SLOTS);
  assign item_used    = (it_kb_q != 16'd0) || (it_size_q != 32'd0) || (it_lc_q != 16'd0);
  assign seen_bit     = ram_rdata[it_blk_q[4:0]];
  assign ram_raddr    = it_blk_q[AddrW+4:5];
  assign ram_re       = (state_q == ST_EXEC);

  // Lowest pending counter bump
  always_comb begin
    bump_idx = 3'd0;
    for (int i = bbcc_pkg::NumStat - 1; i >= 0; i--) begin
      if (pend_q[i]) bump_idx = 3'(i);
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    pend_d      = pend_q;
    stat_d      = stat_q;
    err_total_d = err_total_q;
    clean_d     = clean_q;
    aborted_d   = aborted_q;
    cur_ino_d   = cur_ino_q;
    cur_used_d  = cur_used_q;
    root_mode_d = root_mode_q;

    out_valid_d = 1'b0;
    out_kind_d  = out_kind_q;
    out_code_d  = out_code_q;
    out_ino_d   = out_ino_q;
    out_blk_d   = out_blk_q;
    out_det_d   = out_det_q;
    out_cid_d   = out_cid_q;
    out_cval_d  = out_cval_q;
    out_clean_d = out_clean_q;
    out_last_d  = out_last_q;

    err_fire = 1'b0;
    err_last = 1'b1;
    err_code = bbcc_pkg::ERR_MAGIC;
    err_ino  = 16'd0;
    err_blk  = 32'd0;
    err_det  = 32'd0;

    ram_we    = 1'b0;
    ram_waddr = it_blk_q[AddrW+4:5];
    ram_wdata = ram_rdata | (bbcc_pkg::RowBits'(1) << it_blk_q[4:0]);

    alu_req.op = bbcc_pkg::ALU_INC;
    alu_req.a  = err_total_q;
    alu_req.b  = 32'd0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LastRow) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        if (start && !aborted_q) state_d = ST_EXEC;
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (it_mode_q)
          bbcc_pkg::MODE_SUPER: begin
            if (it_magic_q != exp_magic_q) begin
              err_fire  = 1'b1;
              err_code  = bbcc_pkg::ERR_MAGIC;
              err_det   = it_magic_q;
              aborted_d = 1'b1;
            end else if (it_version_q != exp_version_q) begin
              err_fire = 1'b1;
              err_code = bbcc_pkg::ERR_VERSION;
              err_det  = it_version_q;
            end
          end
          bbcc_pkg::MODE_INODE: begin
            cur_ino_d  = it_ino_q;
            cur_used_d = item_used;
            if (it_ino_q == 16'd0) root_mode_d = it_kb_q;
            if (item_used) begin
              if (!it_imap_q) begin
                err_fire = 1'b1;
                err_code = bbcc_pkg::ERR_ORPHAN_INODE;
                err_ino  = it_ino_q;
                pend_d[bbcc_pkg::ScOrphanInodes] = 1'b1;
              end
              if (it_kb_q[bbcc_pkg::DirBit]) pend_d[bbcc_pkg::ScDirs] = 1'b1;
              else                           pend_d[bbcc_pkg::ScFiles] = 1'b1;
              pend_d[bbcc_pkg::ScInodesUsed] = 1'b1;
              state_d = ST_BUMP;
            end else if (it_imap_q) begin
              err_fire = 1'b1;
              err_code = bbcc_pkg::ERR_DOUBLE_INODE;
              err_ino  = it_ino_q;
            end
          end
          bbcc_pkg::MODE_REF: begin
            if (cur_used_q && it_blk_q != 32'd0) begin
              if (direct_slot) begin
                if (!blk_in_range) begin
                  err_fire = 1'b1;
                  err_code = bbcc_pkg::ERR_BAD_LINK;
                  err_ino  = cur_ino_q;
                  err_blk  = it_blk_q;
                  err_det  = 32'(it_slot_q);
                end else begin
                  state_d = ST_RMW;
                end
              end else if ({1'b0, it_slot_q} == 5'(DIRECT_SLOTS) && blk_in_range) begin
                state_d = ST_RMW;
              end
            end
          end
          bbcc_pkg::MODE_ORPHAN: begin
            if (it_blk_q >= 32'(first_data_block_q) && blk_in_range && it_bm_q) begin
              state_d = ST_RMW;
            end
          end
          bbcc_pkg::MODE_FINISH: begin
            if (!root_mode_q[bbcc_pkg::DirBit]) begin
              err_fire = 1'b1;
              err_last = 1'b0;
              err_code = bbcc_pkg::ERR_ROOT;
              err_det  = 32'(root_mode_q);
            end
            k_d     = 4'd0;
            state_d = ST_FIN;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_RMW: begin
        state_d = ST_BUMP;
        if (it_mode_q == bbcc_pkg::MODE_ORPHAN) begin
          if (!seen_bit) begin
            err_fire = 1'b1;
            err_code = bbcc_pkg::ERR_ORPHAN_BLOCK;
            err_blk  = it_blk_q;
            pend_d[bbcc_pkg::ScOrphanBlocks] = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (direct_slot && seen_bit) begin
          // cross-linked block
          err_fire = 1'b1;
          err_code = bbcc_pkg::ERR_CROSSLINK;
          err_ino  = cur_ino_q;
          err_blk  = it_blk_q;
          pend_d[bbcc_pkg::ScCrosslinks] = 1'b1;
        end else begin
          ram_we = 1'b1;
          pend_d[bbcc_pkg::ScBlocksUsed] = 1'b1;
        end
      end

      ST_BUMP: begin
        alu_req.a        = stat_q[bump_idx];
        stat_d[bump_idx] = alu_y;
        pend_d[bump_idx] = 1'b0;
        if ((pend_q & ~(7'd1 << bump_idx)) == 7'd0) state_d = ST_IDLE;
      end

      ST_FIN: begin
        // one counter report per cycle through the shared unit
        alu_req.op = bbcc_pkg::ALU_SUB;
        unique case (k_q)
          4'd0: alu_req.a = stat_q[bbcc_pkg::ScInodesUsed];
          4'd1: begin
            alu_req.a = 32'(total_inodes_q);
            alu_req.b = stat_q[bbcc_pkg::ScInodesUsed];
          end
          4'd2: alu_req.a = stat_q[bbcc_pkg::ScBlocksUsed];
          4'd3: begin
            alu_req.a = 32'(total_blocks_q);
            alu_req.b = stat_q[bbcc_pkg::ScBlocksUsed];
          end
          4'd9: alu_req.a = err_total_q;
          default: alu_req.a = stat_q[3'(k_q - 4'd2)];
        endcase
        out_valid_d = 1'b1;
        out_kind_d  = bbcc_pkg::KIND_COUNTER;
        out_code_d  = 3'd0;
        out_ino_d   = 16'd0;
        out_blk_d   = 32'd0;
        out_det_d   = 32'd0;
        out_cid_d   = k_q;
        out_cval_d  = alu_y;
        out_clean_d = clean_q;
        out_last_d  = (k_q == bbcc_pkg::CntIdLast);
        if (k_q == bbcc_pkg::CntIdLast) state_d = ST_IDLE;
        else                            k_d = k_q + 4'd1;
      end

      default: state_d = ST_IDLE;
    endcase

    // Error bookkeeping shared by all sources
    if (err_fire) begin
      clean_d     = 1'b0;
      err_total_d = alu_y;
      if (err_total_q < 32'(MAX_ERRORS)) begin
        out_valid_d = 1'b1;
        out_kind_d  = bbcc_pkg::KIND_ERROR;
        out_code_d  = err_code;
        out_ino_d   = err_ino;
        out_blk_d   = err_blk;
        out_det_d   = err_det;
        out_cid_d   = 4'd0;
        out_cval_d  = 32'd0;
        out_clean_d = 1'b0;
        out_last_d  = err_last;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= 4'd0;
      pend_q      <= 7'd0;
      for (int i = 0; i < bbcc_pkg::NumStat; i++) stat_q[i] <= 32'd0;
      err_total_q <= 32'd0;
      clean_q     <= 1'b1;
      aborted_q   <= 1'b0;
      cur_ino_q   <= 16'd0;
      cur_used_q  <= 1'b0;
      root_mode_q <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      stat_q      <= stat_d;
      err_total_q <= err_total_d;
      clean_q     <= clean_d;
      aborted_q   <= aborted_d;
      cur_ino_q   <= cur_ino_d;
      cur_used_q  <= cur_used_d;
      root_mode_q <= root_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q     <= bbcc_pkg::TotalBlocksReset;
      first_data_block_q <= 17'd0;
      total_inodes_q     <= 17'd0;
      exp_magic_q        <= 32'd0;
      exp_version_q      <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbcc_pkg::CFG_TOTAL_BLOCKS:     total_blocks_q     <= cfg_wdata_i[16:0];
        bbcc_pkg::CFG_FIRST_DATA_BLOCK: first_data_block_q <= cfg_wdata_i[16:0];
        bbcc_pkg::CFG_TOTAL_INODES:     total_inodes_q     <= cfg_wdata_i[16:0];
        bbcc_pkg::CFG_EXPECTED_MAGIC:   exp_magic_q        <= cfg_wdata_i;
        bbcc_pkg::CFG_EXPECTED_VERSION: exp_version_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      it_mode_q    <= mode_i;
      it_magic_q   <= magic_value_i;
      it_version_q <= version_value_i;
      it_ino_q     <= inode_number_i;
      it_kb_q      <= inode_kind_bits_i;
      it_size_q    <= file_size_i;
      it_lc_q      <= link_count_i;
      it_imap_q    <= imap_bit_i;
      it_blk_q     <= block_number_i;
      it_slot_q    <= slot_i;
      it_bm_q      <= bmap_bit_i;
    end
    out_kind_q  <= out_kind_d;
    out_code_q  <= out_code_d;
    out_ino_q   <= out_ino_d;
    out_blk_q   <= out_blk_d;
    out_det_q   <= out_det_d;
    out_cid_q   <= out_cid_d;
    out_cval_q  <= out_cval_d;
    out_clean_q <= out_clean_d;
    out_last_q  <= out_last_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign res_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign error_code_o    = out_code_q;
  assign inode_num_o     = out_ino_q;
  assign block_num_o     = out_blk_q;
  assign detail_o        = out_det_q;
  assign counter_id_o    = out_cid_q;
  assign counter_value_o = out_cval_q;
  assign clean_o         = out_clean_q;
  assign last_o          = out_last_q;

`ifndef ASSERT_OFF
  // error records always report a dirty filesystem
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == bbcc_pkg::KIND_ERROR) |-> !clean_o)
    else $error("error record with clean set");

  // the last counter report closes the finish request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == bbcc_pkg::KIND_COUNTER)
      |-> (last_o == (counter_id_o == bbcc_pkg::CntIdLast)))
    else $error("counter report last flag mismatch");

  // error total never goes backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> err_total_q >= $past(err_total_q))
    else $error("error total decreased");

  // a clean flag once cleared stays cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clean_q |=> !clean_q)
    else $error("clean flag set again");
`endif

endmodule

### rtl/bbcc_alu.sv
module bbcc_alu (
  input  bbcc_pkg::alu_req_t req_i,
  output logic [31:0]        y_o
);

  // Saturating increment or floored subtract
  always_comb begin
    unique case (req_i.op)
      bbcc_pkg::ALU_INC: y_o = (&req_i.a) ? req_i.a : req_i.a + 32'd1;
      bbcc_pkg::ALU_SUB: y_o = (req_i.a > req_i.b) ? req_i.a - req_i.b : 32'd0;
    endcase
  end

endmodule

### rtl/bbcc_bitmap_ram.sv
module bbcc_bitmap_ram #(
  parameter int unsigned Rows  = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AddrW-1:0]                    waddr_i,
  input  logic [bbcc_pkg::RowBits-1:0]        wdata_i,
  input  logic                                re_i,
  input  logic [AddrW-1:0]                    raddr_i,
  output logic [bbcc_pkg::RowBits-1:0]        rdata_o
);

  logic [bbcc_pkg::RowBits-1:0] mem [Rows];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
